FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the Booth multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Asserts a property on the rising clock edge, disabled while reset is low.
`define BRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that a condition never holds on the rising clock edge.
`define BRM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BRM_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/brm_pkg.sv
// Package with the shared constants and controller/datapath types of the Booth multiplier.
package brm_pkg;

  // Default operand width in bits.
  localparam int unsigned BrmWidth = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // Take a new operand pair and clear the accumulator.
    logic step;     // Run one Booth add/subtract and shift iteration.
    logic capture;  // Latch the finished product into the output register.
  } brm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // The next iteration is the final one.
  } brm_sts_t;

endpackage

FILE: hw/rtl/brm_in_if.sv
// Input channel interface carrying one operand pair per item.
interface brm_in_if #(
  parameter int unsigned Width = brm_pkg::BrmWidth
);
  logic                    valid;
  logic                    ready;
  logic signed [Width-1:0] multiplicand;
  logic signed [Width-1:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

FILE: hw/rtl/brm_out_if.sv
// Output channel interface carrying one product per item.
interface brm_out_if #(
  parameter int unsigned Width = brm_pkg::BrmWidth
);
  logic                      valid;
  logic                      ready;
  logic signed [2*Width-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

FILE: hw/rtl/brm_ctrl.sv
// Controller state machine of the Booth multiplier.
module brm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brm_pkg::brm_cmd_t cmd_o,
  input  brm_pkg::brm_sts_t sts_i
);
  import brm_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   running;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    running = 1'b0;
    case (state_q)
      StIdle:  running = 1'b0;
      StRun:   running = 1'b1;
      default: running = 1'b0;
    endcase
  end

  // The final iteration waits until the output register can take the product.
  always_comb begin
    in_ready_o    = !running;
    cmd_o.load    = !running && in_valid_i;
    cmd_o.step    = running && (!sts_i.last || out_free);
    cmd_o.capture = running && sts_i.last && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (cmd_o.capture) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/brm_datapath.sv
// Datapath of the Booth multiplier: operand registers, accumulator and product register.
module brm_datapath #(
  parameter int unsigned Width = brm_pkg::BrmWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  brm_pkg::brm_cmd_t         cmd_i,
  output brm_pkg::brm_sts_t         sts_o,
  input  logic signed [Width-1:0]   multiplicand_i,
  input  logic signed [Width-1:0]   multiplier_i,
  output logic signed [2*Width-1:0] product_o
);
  import brm_pkg::*;

  localparam int unsigned CntW = $clog2(Width);

  logic [Width-1:0]   mcand_q;
  logic [Width:0]     acc_q, acc_d;
  logic [Width-1:0]   mplr_q, mplr_d;
  logic               prior_q;
  logic [CntW-1:0]    cnt_q;
  logic [2*Width-1:0] product_q;

  logic [Width:0]     mcand_ext;
  logic [Width:0]     sum;
  logic               q0;

  assign q0        = mplr_q[0];
  assign mcand_ext = {mcand_q[Width-1], mcand_q};

  // Booth recoding of the pair (low multiplier bit, prior bit).
  always_comb begin
    sum = acc_q;
    if (q0 && !prior_q) begin
      sum = acc_q - mcand_ext;
    end else if (!q0 && prior_q) begin
      sum = acc_q + mcand_ext;
    end
  end

  // Arithmetic right shift of the combined accumulator and multiplier register.
  assign acc_d  = {sum[Width], sum[Width:1]};
  assign mplr_d = {sum[0], mplr_q[Width-1:1]};

  assign sts_o.last = (cnt_q == '0);
  assign product_o  = product_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= CntW'(Width - 1);
    end else if (cmd_i.step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q   <= '0;
      mplr_q    <= '0;
      acc_q     <= '0;
      prior_q   <= 1'b0;
      product_q <= '0;
    end else begin
      if (cmd_i.load) begin
        mcand_q <= multiplicand_i;
        mplr_q  <= multiplier_i;
        acc_q   <= '0;
        prior_q <= 1'b0;
      end else if (cmd_i.step) begin
        acc_q   <= acc_d;
        mplr_q  <= mplr_d;
        prior_q <= q0;
      end
      if (cmd_i.capture) begin
        product_q <= {acc_d[Width-1:0], mplr_d};
      end
    end
  end

endmodule

FILE: hw/rtl/booth_radix2_multiplier_unit.sv
// Top level of the radix-2 Booth sequential signed multiplier.
//
//   Channel  Direction  Payload                              Handshake
//   in_i     sink       multiplicand[W-1:0], multiplier[W-1:0]  valid/ready
//   out_o    source     product[2W-1:0]                       valid/ready
//
// An item first loads its operands, then one Booth add/subtract-and-shift
// iteration runs per cycle, once per multiplier bit; only the final
// iteration can hold, waiting for the output register.
// Reset clears the controller state, the output valid flag, the counter and
// every datapath register.
// The finished product sits in an output register, so a new item is accepted
// while the previous product still waits; if that product is still not taken
// when the next one is ready, the final iteration holds until it is.
module booth_radix2_multiplier_unit #(
  parameter int unsigned WIDTH = brm_pkg::BrmWidth
) (
  input logic      clk_i,
  input logic      rst_ni,
  brm_in_if.sink   in_i,
  brm_out_if.source out_o
);
  import brm_pkg::*;

  `include "assert_macros.svh"

  brm_cmd_t cmd;
  brm_sts_t sts;

  // The controller sequences load, iterations and product capture.
  brm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the operands, the widened accumulator and the product.
  brm_datapath #(
    .Width (WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .multiplicand_i (in_i.multiplicand),
    .multiplier_i   (in_i.multiplier),
    .product_o      (out_o.product)
  );

  // An accepted item keeps the input closed for the next cycle.
  `BRM_ASSERT(a_busy_after_load, clk_i, rst_ni, cmd.load |=> !in_i.ready, "input open after load")

  // Loading and iterating never happen in the same cycle.
  `BRM_ASSERT_NEVER(a_load_step, clk_i, rst_ni, cmd.load && cmd.step, "load during iteration")

  // The final iteration always presents a product in the next cycle.
  `BRM_ASSERT(a_capture_valid, clk_i, rst_ni, cmd.capture |=> out_o.valid, "product not presented")

  // The input reopens only after the final iteration.
  `BRM_ASSERT(a_reopen, clk_i, rst_ni, $rose(in_i.ready) |-> $past(cmd.capture), "early reopen")

endmodule

FILE: verif/booth_radix2_multiplier_unit_test.sv
// Self-checking testbench for the radix-2 Booth sequential signed multiplier.
module booth_radix2_multiplier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = brm_pkg::BrmWidth;

  // A phase with no acceptance on either channel for this many cycles is a hang.
  // A product and a receiver stall both take far less than this, so the limit
  // is far above any correct run.
  localparam int unsigned StallLimit = 4000;

  // Cycles to let pass after the last expected product, to catch extra ones.
  localparam int unsigned DrainCycles = 4 * (W + 1);

  // Number of random items in each of the three idling phases.
  localparam int unsigned RandomPerPhase = 165;

  // One pending operand pair. When hold_for_drain is set, the driver does not
  // offer the item until every product expected so far has come back.
  typedef struct {
    logic [W-1:0] multiplicand;
    logic [W-1:0] multiplier;
    bit           hold_for_drain;
  } operand_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  brm_in_if  #(.Width(W)) in_bus ();
  brm_out_if #(.Width(W)) out_bus ();

  booth_radix2_multiplier_unit #(
    .WIDTH(W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #5 clk_i = ~clk_i;

  operand_pair_t             pending_pairs[$];
  logic signed [2*W-1:0]     expected_products[$];
  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;
  int unsigned               mismatches;
  int unsigned               quiet_cycles;
  bit                        timed_out;

  // Prints one line about a mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Booth recoding of the multiplier, one bit pair per iteration, with an
  // accumulator one bit wider than the operands so that the most negative
  // multiplicand cannot overflow it.
  function automatic logic signed [2*W-1:0] booth_product(input logic [W-1:0] mcand,
                                                          input logic [W-1:0] mplier);
    logic [W:0]   acc;
    logic [W:0]   mcand_ext;
    logic [W-1:0] q;
    logic         q_prev;
    acc       = '0;
    q         = mplier;
    q_prev    = 1'b0;
    mcand_ext = {mcand[W-1], mcand};
    for (int i = 0; i < W; i++) begin
      // A 1 after a 0 starts a run of ones: subtract. The end of a run adds.
      if (q[0] && !q_prev) begin
        acc = acc - mcand_ext;
      end else if (!q[0] && q_prev) begin
        acc = acc + mcand_ext;
      end
      q_prev = q[0];
      q      = {acc[0], q[W-1:1]};
      acc    = {acc[W], acc[W:1]};
    end
    return {acc[W-1:0], q};
  endfunction

  // Operand values weighted toward the corners: the most negative and most
  // positive values, zero, minus one and small numbers, then anything at all.
  function automatic logic [W-1:0] random_operand();
    logic signed [W-1:0] v;
    v = '0;
    case ($urandom_range(0, 9))
      0: v = {1'b1, {(W-1){1'b0}}};
      1: v = {1'b0, {(W-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      4: begin
        v = W'($urandom_range(0, 16));
        v = v - W'(8);
      end
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_pair(input logic [W-1:0] mcand, input logic [W-1:0] mplier,
                            input bit hold);
    operand_pair_t p;
    p.multiplicand   = mcand;
    p.multiplier     = mplier;
    p.hold_for_drain = hold;
    pending_pairs.push_back(p);
  endtask

  // Driver: records the expected product of every accepted item, then offers
  // the next pending item unless the sender idles this cycle or the item waits
  // for the drain. A valid that stays high is simply left alone, so it is
  // never lowered and raised in the same time step.
  always @(posedge clk_i or negedge rst_ni) begin
    operand_pair_t next_pair;
    if (!rst_ni) begin
      in_bus.valid        <= 1'b0;
      in_bus.multiplicand <= '0;
      in_bus.multiplier   <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_products.push_back(booth_product(in_bus.multiplicand, in_bus.multiplier));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            (!pending_pairs[0].hold_for_drain || expected_products.size() == 0)) begin
          next_pair = pending_pairs.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.multiplicand <= next_pair.multiplicand;
          in_bus.multiplier   <= next_pair.multiplier;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver stalls at random, and every accepted product is
  // compared with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [2*W-1:0] want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_products.size() == 0) begin
          report_mismatch($sformatf("product %0d with nothing expected", out_bus.product));
        end else begin
          want = expected_products.pop_front();
          if (out_bus.product !== want) begin
            report_mismatch($sformatf("product %0d, expected %0d", out_bus.product, want));
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel accepts an item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits on the falling edge so that queue and idling changes never race
  // with the clocked blocks above.
  task automatic wait_pending_empty();
    while (pending_pairs.size() != 0 || in_bus.valid) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    // Every input gets a known value at time zero; reset falls a moment later
    // so that every block with an asynchronous reset sees its edge.
    rst_ni              = 1'b1;
    in_bus.valid        = 1'b0;
    in_bus.multiplicand = '0;
    in_bus.multiplier   = '0;
    out_bus.ready       = 1'b0;
    send_idle_pct       = 26;
    recv_idle_pct       = 47;
    mismatches          = 0;
    timed_out           = 1'b0;
    #1;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      begin
        // Directed items: operand extremes in every combination, the most
        // negative value times itself, unit and minus-one factors, and
        // alternating bit patterns that force an add or subtract on every
        // iteration, or on all but the first.
        queue_pair({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}}, 1'b0);
        queue_pair({1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}}, 1'b0);
        queue_pair({1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}}, 1'b0);
        queue_pair({1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}, 1'b0);
        queue_pair('0, '0, 1'b0);
        queue_pair('0, {1'b1, {(W-1){1'b0}}}, 1'b0);
        queue_pair({1'b1, {(W-1){1'b0}}}, '0, 1'b0);
        queue_pair({1'b1, {(W-1){1'b0}}}, '1, 1'b0);
        queue_pair('1, {1'b1, {(W-1){1'b0}}}, 1'b0);
        queue_pair({1'b1, {(W-1){1'b0}}}, W'(1), 1'b0);
        queue_pair(W'(1), {1'b1, {(W-1){1'b0}}}, 1'b0);
        queue_pair('1, '1, 1'b0);
        queue_pair('1, W'(1), 1'b0);
        queue_pair(W'(1), '1, 1'b0);
        queue_pair({(W/2){2'b01}}, {(W/2){2'b10}}, 1'b0);
        queue_pair({(W/2){2'b10}}, {(W/2){2'b01}}, 1'b0);
        queue_pair({(W/2){2'b10}}, {(W/2){2'b10}}, 1'b0);
        queue_pair(W'(12345), W'(-6789), 1'b0);
        queue_pair(W'(-3), W'(7), 1'b0);

        // Random items in three phases: sender idles more lightly than the
        // receiver, then the reverse, then neither idles so items run back
        // to back. The first item of each phase waits for the block to drain.
        for (int phase = 0; phase < 3; phase++) begin
          for (int n = 0; n < RandomPerPhase; n++) begin
            queue_pair(random_operand(), random_operand(), n == 0);
          end
          wait_pending_empty();
          if (phase == 0) begin
            send_idle_pct = 47;
            recv_idle_pct = 26;
          end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        end

        while (expected_products.size() != 0) begin
          @(negedge clk_i);
        end
        repeat (DrainCycles) @(negedge clk_i);
      end
      begin
        while (quiet_cycles < StallLimit) begin
          @(negedge clk_i);
        end
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && expected_products.size() != 0) begin
      report_mismatch($sformatf("%0d products never arrived", expected_products.size()));
    end

    if (!timed_out && mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
